// File: hw/rtl/fhvp_pkg.sv
// Shared constants and types for the frame header parser.
package fhvp_pkg;

  localparam int unsigned LEN_W   = 24;
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned IDENT_W = 62;
  localparam int unsigned HB_W    = 4;
  localparam int unsigned POS_W   = 4;

  localparam logic [7:0] SIZE_MASK  = 8'hc0;
  localparam logic [7:0] VALUE_MASK = 8'h3f;

  localparam logic [TYPE_W-1:0] TYPE_STREAM = 8'd0;
  localparam logic [TYPE_W-1:0] TYPE_WINDOW = 8'd4;

  localparam logic [POS_W-1:0] POS_TYPE   = 4'd3;
  localparam logic [POS_W-1:0] POS_VFIRST = 4'd4;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  // varint size codes
  localparam logic [1:0] VSIZE_1 = 2'd0;
  localparam logic [1:0] VSIZE_2 = 2'd1;
  localparam logic [1:0] VSIZE_4 = 2'd2;
  localparam logic [1:0] VSIZE_8 = 2'd3;

  // Byte position of the last stream id byte for a given size code.
  function automatic logic [POS_W-1:0] vlast_pos(input logic [1:0] code);
    logic [POS_W-1:0] p;
    case (code)
      VSIZE_1: p = 4'd4;
      VSIZE_2: p = 4'd5;
      VSIZE_4: p = 4'd7;
      VSIZE_8: p = 4'd11;
      default: p = 4'd11;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/fhvp_if.sv
// Channel interfaces: input byte items and header result items.
interface fhvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fhvp_out_if import fhvp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   frame_length;
  logic [TYPE_W-1:0]  frame_type;
  logic [IDENT_W-1:0] stream_ident;
  logic [HB_W-1:0]    header_bytes;
  logic               status;
  modport source (output valid, output frame_length, output frame_type,
                  output stream_ident, output header_bytes, output status,
                  input ready);
  modport sink   (input valid, input frame_length, input frame_type,
                  input stream_ident, input header_bytes, input status,
                  output ready);
endinterface

// File: hw/rtl/frame_header_varint_parser_top.sv
// Frame header parser top level: length, type and varint stream id from a byte stream.
//
//  channel   | dir | payload                                             | item
//  ----------+-----+-----------------------------------------------------+------------------
//  in_port   | in  | data_byte[7:0], last_byte                           | one buffer byte
//  out_port  | out | frame_length[23:0], frame_type[7:0],                | one header result
//            |     | stream_ident[61:0], header_bytes[3:0], status       |
//
// One byte item is taken per clock while in_port.ready is high. The parse state and the
// result register are updated in the same cycle as the accept, so a result shows on
// out_port in the cycle after the byte that completes (or truncates) the header.
// in_port.ready drops only while a result is held and out_port.ready is low;
// a result that is taken in the same cycle frees the register for the next one.
// rst (synchronous, active high) clears the parse state and drops out_port.valid.
module frame_header_varint_parser_top import fhvp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  fhvp_in_if.sink          in_port,
  fhvp_out_if.source       out_port
);

  // parse state
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [LEN_W-1:0]   length_accum, length_accum_next;
  logic [TYPE_W-1:0]  type_reg, type_reg_next;
  logic [1:0]         varint_size_code, varint_size_code_next;
  logic [IDENT_W-1:0] ident_accum, ident_accum_next;
  logic               skipping_rest, skipping_rest_next;

  // result register
  logic               res_valid;
  logic [LEN_W-1:0]   res_length;
  logic [TYPE_W-1:0]  res_type;
  logic [IDENT_W-1:0] res_ident;
  logic [HB_W-1:0]    res_hbytes;
  logic               res_status;

  logic               accept;
  logic               emit, done;
  logic [LEN_W-1:0]   emit_length;
  logic [TYPE_W-1:0]  emit_type;
  logic [IDENT_W-1:0] emit_ident;
  logic [HB_W-1:0]    emit_hbytes;
  logic               emit_status;

  logic [7:0]         b;
  logic               last;

  assign b    = in_port.data_byte;
  assign last = in_port.last_byte;

  // Result register doubles as the skid: free when empty or being drained.
  assign in_port.ready = !res_valid || out_port.ready;
  assign accept        = in_port.valid && in_port.ready;

  always_comb begin
    byte_position_next    = byte_position;
    length_accum_next     = length_accum;
    type_reg_next         = type_reg;
    varint_size_code_next = varint_size_code;
    ident_accum_next      = ident_accum;
    skipping_rest_next    = skipping_rest;
    done                  = 1'b0;
    emit                  = 1'b0;
    emit_length           = '0;
    emit_type             = '0;
    emit_ident            = '0;
    emit_hbytes           = '0;
    emit_status           = STATUS_OK;

    if (skipping_rest) begin
      // tail of a parsed frame: drop bytes until the buffer ends
      if (last) begin
        skipping_rest_next    = 1'b0;
        byte_position_next    = '0;
        length_accum_next     = '0;
        type_reg_next         = '0;
        varint_size_code_next = '0;
        ident_accum_next      = '0;
      end
    end else begin
      if (byte_position < POS_TYPE) begin
        length_accum_next  = {length_accum[LEN_W-9:0], b};
        byte_position_next = byte_position + 4'd1;
      end else if (byte_position == POS_TYPE) begin
        type_reg_next = b;
        if (b == TYPE_STREAM || b == TYPE_WINDOW) begin
          byte_position_next = POS_VFIRST;
        end else begin
          ident_accum_next = '0;
          done             = 1'b1;
        end
      end else if (byte_position == POS_VFIRST) begin
        varint_size_code_next = b[7:6];
        ident_accum_next      = {{(IDENT_W-8){1'b0}}, b & VALUE_MASK};
        if ((b & SIZE_MASK) == 8'h00) begin
          done = 1'b1;
        end else begin
          byte_position_next = byte_position + 4'd1;
        end
      end else begin
        ident_accum_next = {ident_accum[IDENT_W-9:0], b};
        if (byte_position >= vlast_pos(varint_size_code)) begin
          done = 1'b1;
        end else begin
          byte_position_next = byte_position + 4'd1;
        end
      end

      if (done) begin
        emit        = 1'b1;
        emit_length = length_accum_next;
        emit_type   = type_reg_next;
        emit_ident  = ident_accum_next;
        emit_hbytes = byte_position + 4'd1;
        emit_status = STATUS_OK;
        skipping_rest_next = !last;
      end else if (last) begin
        // buffer ended mid-header: all-zero result with the error flag
        emit        = 1'b1;
        emit_status = STATUS_TRUNC;
        skipping_rest_next = 1'b0;
      end

      if (emit) begin
        byte_position_next    = '0;
        length_accum_next     = '0;
        type_reg_next         = '0;
        varint_size_code_next = '0;
        ident_accum_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      length_accum     <= '0;
      type_reg         <= '0;
      varint_size_code <= '0;
      ident_accum      <= '0;
      skipping_rest    <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (accept) begin
        byte_position    <= byte_position_next;
        length_accum     <= length_accum_next;
        type_reg         <= type_reg_next;
        varint_size_code <= varint_size_code_next;
        ident_accum      <= ident_accum_next;
        skipping_rest    <= skipping_rest_next;
      end
      if (accept) begin
        res_valid <= emit;
      end else if (out_port.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload of the result register, loaded only with a new result
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_length <= emit_length;
      res_type   <= emit_type;
      res_ident  <= emit_ident;
      res_hbytes <= emit_hbytes;
      res_status <= emit_status;
    end
  end

  assign out_port.valid        = res_valid;
  assign out_port.frame_length = res_length;
  assign out_port.frame_type   = res_type;
  assign out_port.stream_ident = res_ident;
  assign out_port.header_bytes = res_hbytes;
  assign out_port.status       = res_status;

endmodule

// File: hw/rtl/fhvp_checker.sv
// Port-level assertions for the frame header parser, bound to the top level.
module fhvp_checker import fhvp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LEN_W-1:0]   frame_length,
  input logic [TYPE_W-1:0]  frame_type,
  input logic [IDENT_W-1:0] stream_ident,
  input logic [HB_W-1:0]    header_bytes,
  input logic               status
);

  // a held result keeps its length, stream id, header size and status
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_length) &&
      $stable(stream_ident) && $stable(header_bytes) && $stable(status))
    else $error("result changed while stalled");

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |->
      header_bytes == 4'd4 || header_bytes == 4'd5 || header_bytes == 4'd6 ||
      header_bytes == 4'd8 || header_bytes == 4'd12)
    else $error("bad header size on success");

  a_trunc_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_TRUNC |->
      frame_length == '0 && frame_type == '0 && stream_ident == '0 &&
      header_bytes == '0)
    else $error("truncation result carries data");

  a_no_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK && frame_type != TYPE_STREAM &&
      frame_type != TYPE_WINDOW |-> header_bytes == 4'd4 && stream_ident == '0)
    else $error("stream id on a type without one");

endmodule

bind frame_header_varint_parser_top fhvp_checker u_fhvp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_port.valid),
  .out_ready    (out_port.ready),
  .frame_length (out_port.frame_length),
  .frame_type   (out_port.frame_type),
  .stream_ident (out_port.stream_ident),
  .header_bytes (out_port.header_bytes),
  .status       (out_port.status)
);

// File: sim/tb_frame_header_varint_parser_top.sv
// Testbench for the frame header parser: directed table, random buffers, scoreboard.
module tb_frame_header_varint_parser_top import fhvp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // One header result item, laid out as on out_port.
  typedef struct packed {
    logic [LEN_W-1:0]   frame_length;
    logic [TYPE_W-1:0]  frame_type;
    logic [IDENT_W-1:0] stream_ident;
    logic [HB_W-1:0]    header_bytes;
    logic               status;
  } hdr_result_t;

  // Directed row: one byte item, plus a typed-in result where it is obvious.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    hdr_result_t want;
  } dir_row_t;

  localparam hdr_result_t NO_RESULT    = '0;
  localparam hdr_result_t TRUNC_RESULT = '{24'd0, 8'd0, 62'd0, 4'd0, STATUS_TRUNC};
  localparam int          DIR_ROWS     = 27;
  localparam int          RANDOM_ITEMS = 1550;
  localparam int          LONG_HOLD    = 400;   // receiver hold-off, in cycles
  localparam int          DRAIN_CYCLES = 4;     // result shows in the cycle after its byte

  // Directed buffers:
  //  - end mark on the very first byte: truncation
  //  - all-ones length, unknown type 0xff, header ends on the end mark
  //  - stream frame, zero length, 1-byte id of max value, then one skipped byte
  //  - window update with an 8-byte id of all ones, ends on the end mark
  //  - stream frame cut off at the type byte: truncation
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, TRUNC_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b1, 1'b1, '{24'hff_ffff, 8'hff, 62'd0, 4'd4, STATUS_OK}},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{TYPE_STREAM, 1'b0, 1'b0, NO_RESULT},
    '{8'h3f, 1'b0, 1'b1, '{24'd0, TYPE_STREAM, 62'h3f, 4'd5, STATUS_OK}},
    '{8'hc0, 1'b1, 1'b0, NO_RESULT},
    '{8'h12, 1'b0, 1'b0, NO_RESULT},
    '{8'h34, 1'b0, 1'b0, NO_RESULT},
    '{8'h56, 1'b0, 1'b0, NO_RESULT},
    '{TYPE_WINDOW, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b1, 1'b1,
      '{24'h12_3456, TYPE_WINDOW, 62'h3fff_ffff_ffff_ffff, 4'd12, STATUS_OK}},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, 1'b0, NO_RESULT},
    '{TYPE_STREAM, 1'b1, 1'b1, TRUNC_RESULT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  fhvp_in_if  in_ch ();
  fhvp_out_if out_ch ();

  frame_header_varint_parser_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_port  (in_ch),
    .out_port (out_ch)
  );

  always #5 clk = ~clk;

  // Header parse state mirrored by the predictor.
  logic [POS_W-1:0]   hdr_pos     = '0;
  logic [LEN_W-1:0]   hdr_len     = '0;
  logic [TYPE_W-1:0]  hdr_type    = '0;
  logic [1:0]         id_code     = '0;
  logic [IDENT_W-1:0] id_accum    = '0;
  logic               skip_to_end = 1'b0;

  hdr_result_t hdr_expect_q[$];   // header results still owed by the block

  int errors     = 0;
  int items_sent = 0;
  int hold_asks  = 0;   // bumped by the sender to request a long receiver hold-off
  int hold_seen  = 0;
  int hold_left  = 0;
  int out_gap    = 0;
  bit in_calm    = 1'b0;
  bit out_calm   = 1'b0;

  function automatic void clear_header();
    hdr_pos  = '0;
    hdr_len  = '0;
    hdr_type = '0;
    id_code  = '0;
    id_accum = '0;
  endfunction

  // Advance the header parser by one byte; returns 1 when a result is due.
  function automatic bit predict_header(input logic [7:0] b, input logic l,
                                        output hdr_result_t r);
    logic [POS_W-1:0] p;
    bit               done;
    p    = hdr_pos;
    done = 1'b0;
    r    = NO_RESULT;
    // after a parsed header, everything up to the end mark is dropped
    if (skip_to_end) begin
      if (l) begin
        skip_to_end = 1'b0;
        clear_header();
      end
      return 1'b0;
    end
    if (p < POS_TYPE) begin
      hdr_len = {hdr_len[LEN_W-9:0], b};
      hdr_pos = p + 1'b1;
    end else if (p == POS_TYPE) begin
      hdr_type = b;
      if (b == TYPE_STREAM || b == TYPE_WINDOW) begin
        hdr_pos = POS_VFIRST;
      end else begin
        id_accum = '0;
        done     = 1'b1;
      end
    end else if (p == POS_VFIRST) begin
      // size code lives in the top two bits and is not part of the value
      id_code  = b[7:6];
      id_accum = IDENT_W'(b & VALUE_MASK);
      if (id_code == VSIZE_1) begin
        done = 1'b1;
      end else begin
        hdr_pos = p + 1'b1;
      end
    end else begin
      id_accum = {id_accum[IDENT_W-9:0], b};
      // id of 2^code bytes starts right after the type byte
      if (int'(p) >= int'(POS_TYPE) + (1 << id_code)) begin
        done = 1'b1;
      end else begin
        hdr_pos = p + 1'b1;
      end
    end
    if (done) begin
      r = '{hdr_len, hdr_type, id_accum, HB_W'(p + 1'b1), STATUS_OK};
      clear_header();
      skip_to_end = !l;   // header ending on the end mark restarts at once
      return 1'b1;
    end
    if (l) begin
      r = TRUNC_RESULT;
      clear_header();
      skip_to_end = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Idle length: mostly none or short, now and then long; none in calm stretches.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte item from a falling edge; returns at the falling edge after
  // it was taken. The expectation is queued at the accepting rising edge.
  task automatic push_byte(input logic [7:0] b, input logic l, input logic typed,
                           input hdr_result_t want);
    int          gap;
    bit          due;
    hdr_result_t got;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= l;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    due = predict_header(b, l, got);
    if (typed) begin
      hdr_expect_q.push_back(want);
    end else if (due) begin
      hdr_expect_q.push_back(got);
    end
    @(negedge clk);
  endtask

  // One random buffer: mostly a well-formed header with random content, some
  // cut short by the end mark, the rest plain noise.
  task automatic send_frame();
    logic [7:0] frm[$];
    logic [7:0] ftype;
    logic [1:0] code;
    int         kind;
    int         cut;
    int         tail;
    int         n;
    kind = $urandom_range(0, 99);
    if (kind >= 85) begin
      n = $urandom_range(1, 8);
      repeat (n) push_byte(8'($urandom), 1'($urandom), 1'b0, NO_RESULT);
      return;
    end
    // length: extremes now and then
    case ($urandom_range(0, 9))
      0: begin
        repeat (3) frm.push_back(8'h00);
      end
      1: begin
        repeat (3) frm.push_back(8'hff);
      end
      default: begin
        repeat (3) frm.push_back(8'($urandom));
      end
    endcase
    n = $urandom_range(0, 99);
    if (n < 40) begin
      ftype = TYPE_STREAM;
    end else if (n < 75) begin
      ftype = TYPE_WINDOW;
    end else if (n < 90) begin
      ftype = 8'($urandom_range(1, 3));
    end else begin
      ftype = 8'($urandom);
    end
    frm.push_back(ftype);
    if (ftype == TYPE_STREAM || ftype == TYPE_WINDOW) begin
      code = 2'($urandom);
      frm.push_back({code, 6'($urandom)});
      repeat ((1 << code) - 1) frm.push_back(8'($urandom));
    end
    if (kind < 70) begin
      // tail of zero puts the end mark on the last header byte
      tail = $urandom_range(0, 3);
      foreach (frm[i]) push_byte(frm[i], (tail == 0) && (i == frm.size() - 1), 1'b0,
                                 NO_RESULT);
      for (int k = 1; k <= tail; k++) push_byte(8'($urandom), k == tail, 1'b0, NO_RESULT);
    end else begin
      cut = $urandom_range(0, frm.size() - 2);
      for (int k = 0; k <= cut; k++) push_byte(frm[k], k == cut, 1'b0, NO_RESULT);
    end
  endtask

  // Stimulus: reset, directed table, then random buffers until the budget is spent.
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      push_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end
    items_sent = 0;
    hold_asks++;   // first long hold-off while the sender keeps offering bytes
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) in_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 15) == 0) out_calm = ($urandom_range(0, 3) == 0);
      if (items_sent >= RANDOM_ITEMS / 2 && hold_asks < 2) hold_asks++;
      send_frame();
    end
    in_ch.valid <= 1'b0;
    while (hdr_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random back-pressure, calm stretches, and the requested long hold.
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap = pick_gap(out_calm);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Scoreboard: every result item taken is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    hdr_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (hdr_expect_q.size() == 0) begin
        $error("result item with no expectation pending");
        errors++;
      end else begin
        want = hdr_expect_q.pop_front();
        check_field("frame_length", 64'(want.frame_length), 64'(out_ch.frame_length));
        check_field("frame_type", 64'(want.frame_type), 64'(out_ch.frame_type));
        check_field("stream_ident", 64'(want.stream_ident), 64'(out_ch.stream_ident));
        check_field("header_bytes", 64'(want.header_bytes), 64'(out_ch.header_bytes));
        check_field("status", 64'(want.status), 64'(out_ch.status));
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: frame_header_varint_parser_top.f
hw/rtl/fhvp_pkg.sv
hw/rtl/fhvp_if.sv
hw/rtl/frame_header_varint_parser_top.sv
hw/rtl/fhvp_checker.sv
sim/tb_frame_header_varint_parser_top.sv
